### hw/rtl/bpsd_pkg.sv
// Shared types and constants for the bright pixel steering decider.
// Holds command codes, register indexes and the controller/datapath structs.
// No dependencies.
package bpsd_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 13;
  localparam int CountW   = 27;

  localparam logic [CfgIdxW-1:0] CFG_FRAME_WIDTH     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_FRAME_HEIGHT    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_BYTES_PER_PIXEL = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_WHITE_LEVEL     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_CLOSE_PERCENT   = 3'd4;

  localparam logic [1:0] CMD_STOP    = 2'd0;
  localparam logic [1:0] CMD_LEFT    = 2'd1;
  localparam logic [1:0] CMD_RIGHT   = 2'd2;
  localparam logic [1:0] CMD_FORWARD = 2'd3;

  localparam logic [CountW-1:0] COUNT_MAX = {CountW{1'b1}};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic mul_area;
    logic mul_bytes;
    logic mul_limit;
    logic decide;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic frame_last;
    logic out_busy;
  } status_t;

endpackage

### hw/rtl/bpsd_ctrl.sv
// Controller state machine for the bright pixel steering decider.
// Sequences byte intake and the end-of-frame threshold calculation.
// Depends on bpsd_pkg.
module bpsd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bpsd_pkg::status_t status_i,
  output bpsd_pkg::ctrl_t   ctrl_o
);

  typedef enum logic [4:0] {
    ST_RUN    = 5'b00001,
    ST_AREA   = 5'b00010,
    ST_BYTES  = 5'b00100,
    ST_LIMIT  = 5'b01000,
    ST_DECIDE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    case (state_q)
      ST_RUN: begin
        ctrl_o.accept = in_valid_i;
        if (in_valid_i && status_i.frame_last) begin
          state_d = ST_AREA;
        end
      end
      ST_AREA: begin
        ctrl_o.mul_area = 1'b1;
        state_d = ST_BYTES;
      end
      ST_BYTES: begin
        ctrl_o.mul_bytes = 1'b1;
        state_d = ST_LIMIT;
      end
      ST_LIMIT: begin
        ctrl_o.mul_limit = 1'b1;
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        // Wait until the output register can take a new result.
        if (!status_i.out_busy) begin
          ctrl_o.decide = 1'b1;
          state_d = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_RUN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hw/rtl/bpsd_datapath.sv
// Datapath for the bright pixel steering decider: configuration registers,
// raster counters, white byte tally, threshold multiplies and output register.
// Depends on bpsd_pkg.
module bpsd_datapath #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [bpsd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bpsd_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic [7:0]                    data_byte_i,
  input  logic                          out_stall_i,
  input  bpsd_pkg::ctrl_t               ctrl_i,
  output bpsd_pkg::status_t             status_o,
  output logic                          out_valid_o,
  output logic [1:0]                    command_o,
  output logic [bpsd_pkg::CountW-1:0]   white_count_o
);

  localparam int WCW = $clog2(MAX_WIDTH + 1);
  localparam int HCW = $clog2(MAX_HEIGHT + 1);
  localparam int CIW = $clog2(MAX_WIDTH);
  localparam int RIW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW  = WCW + HCW;
  localparam int TW  = AW + 3;
  localparam int LW  = TW + 7;
  localparam int PW  = bpsd_pkg::CountW + 7;
  localparam int CW  = (LW > PW) ? LW : PW;

  // Configuration registers.
  logic [12:0] width_q, height_q;
  logic [2:0]  bpp_q;
  logic [7:0]  white_q;
  logic [6:0]  close_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd640;
      height_q <= 13'd480;
      bpp_q    <= 3'd3;
      white_q  <= 8'd255;
      close_q  <= 7'd15;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bpsd_pkg::CFG_FRAME_WIDTH:     width_q  <= cfg_data_i;
        bpsd_pkg::CFG_FRAME_HEIGHT:    height_q <= cfg_data_i;
        bpsd_pkg::CFG_BYTES_PER_PIXEL: bpp_q    <= cfg_data_i[2:0];
        bpsd_pkg::CFG_WHITE_LEVEL:     white_q  <= cfg_data_i[7:0];
        bpsd_pkg::CFG_CLOSE_PERCENT:   close_q  <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Effective, saturated frame geometry.
  logic [WCW-1:0] w_eff, quarter, three_q4, col_ext;
  logic [HCW-1:0] h_eff;
  logic [2:0]     bpp_eff;

  always_comb begin
    if (width_q < 13'd4) begin
      w_eff = WCW'(4);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_eff = WCW'(MAX_WIDTH);
    end else begin
      w_eff = WCW'(width_q);
    end
    if (height_q == 13'd0) begin
      h_eff = HCW'(1);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      h_eff = HCW'(MAX_HEIGHT);
    end else begin
      h_eff = HCW'(height_q);
    end
    if (bpp_q == 3'd0) begin
      bpp_eff = 3'd1;
    end else if (bpp_q > 3'd4) begin
      bpp_eff = 3'd4;
    end else begin
      bpp_eff = bpp_q;
    end
  end

  assign quarter  = w_eff >> 2;
  assign three_q4 = quarter + (quarter << 1);

  // Raster position.
  logic [1:0]     byte_q, byte_d;
  logic [CIW-1:0] col_q, col_d;
  logic [RIW-1:0] row_q, row_d;
  logic           byte_last, col_last, row_last;

  assign col_ext   = WCW'(col_q);
  assign byte_last = ({1'b0, byte_q} + 3'd1) >= bpp_eff;
  assign col_last  = (col_ext + WCW'(1)) >= w_eff;
  assign row_last  = (HCW'(row_q) + HCW'(1)) >= h_eff;

  assign status_o.frame_last = byte_last && col_last && row_last;

  // Frame statistics.
  logic [bpsd_pkg::CountW-1:0] hit_q, hit_d;
  logic                        ball_q, ball_d;
  logic [1:0]                  heading_q, heading_d;
  logic                        stopped_q, stopped_d;

  // Output register.
  logic                        out_valid_q, out_valid_d;
  logic [1:0]                  command_q, command_d;
  logic [bpsd_pkg::CountW-1:0] count_q, count_d;

  // Threshold products.
  logic [AW-1:0] area_q;
  logic [TW-1:0] total_q;
  logic [LW-1:0] limit_q;
  logic [PW-1:0] scaled_q;
  logic          too_close;

  assign too_close = CW'(scaled_q) > CW'(limit_q);

  always_comb begin
    byte_d      = byte_q;
    col_d       = col_q;
    row_d       = row_q;
    hit_d       = hit_q;
    ball_d      = ball_q;
    heading_d   = heading_q;
    stopped_d   = stopped_q;
    out_valid_d = out_valid_q && out_stall_i;
    command_d   = command_q;
    count_d     = count_q;

    if (ctrl_i.accept) begin
      if (data_byte_i == white_q) begin
        ball_d = 1'b1;
        if (hit_q != bpsd_pkg::COUNT_MAX) begin
          hit_d = hit_q + 1'b1;
        end
        // A white byte exactly on a quarter boundary keeps the heading.
        if (col_ext < quarter) begin
          heading_d = bpsd_pkg::CMD_LEFT;
        end else if (col_ext > quarter && col_ext < three_q4) begin
          heading_d = bpsd_pkg::CMD_FORWARD;
        end else if (col_ext > three_q4) begin
          heading_d = bpsd_pkg::CMD_RIGHT;
        end
      end
      if (byte_last) begin
        byte_d = 2'd0;
        if (col_last) begin
          col_d = '0;
          if (row_last) begin
            row_d = '0;
          end else begin
            row_d = row_q + 1'b1;
          end
        end else begin
          col_d = col_q + 1'b1;
        end
      end else begin
        byte_d = byte_q + 2'd1;
      end
    end

    if (ctrl_i.decide) begin
      if (ball_q) begin
        out_valid_d = 1'b1;
        count_d     = hit_q;
        if (too_close) begin
          command_d = bpsd_pkg::CMD_STOP;
          stopped_d = 1'b1;
        end else begin
          command_d = heading_q;
          stopped_d = 1'b0;
        end
      end else if (!stopped_q) begin
        // Ball lost while moving: stop once.
        out_valid_d = 1'b1;
        command_d   = bpsd_pkg::CMD_STOP;
        count_d     = '0;
        stopped_d   = 1'b1;
      end
      hit_d     = '0;
      ball_d    = 1'b0;
      heading_d = bpsd_pkg::CMD_FORWARD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q      <= 2'd0;
      col_q       <= '0;
      row_q       <= '0;
      hit_q       <= '0;
      ball_q      <= 1'b0;
      heading_q   <= bpsd_pkg::CMD_FORWARD;
      stopped_q   <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      byte_q      <= byte_d;
      col_q       <= col_d;
      row_q       <= row_d;
      hit_q       <= hit_d;
      ball_q      <= ball_d;
      heading_q   <= heading_d;
      stopped_q   <= stopped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    command_q <= command_d;
    count_q   <= count_d;
    if (ctrl_i.mul_area) begin
      area_q <= AW'(w_eff) * AW'(h_eff);
    end
    if (ctrl_i.mul_bytes) begin
      total_q <= TW'(area_q) * TW'(bpp_eff);
    end
    if (ctrl_i.mul_limit) begin
      limit_q  <= LW'(total_q) * LW'(close_q);
      scaled_q <= PW'(hit_q) * PW'(100);
    end
  end

  assign status_o.out_busy = out_valid_q && out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign command_o         = command_q;
  assign white_count_o     = count_q;

endmodule

### hw/rtl/bright_pixel_steering_decider.sv
// Top level of the bright pixel steering decider.
// Joins the controller (bpsd_ctrl) and the datapath (bpsd_datapath); uses bpsd_pkg.
//
// Usage:
//   Image bytes enter in raster order on data_byte_i, one item per cycle while
//   in_stall_o is low. Frame geometry, the white level and the stop percentage
//   are written through the configuration channel (cfg_ready_o is always high).
//   At most one result is produced per frame, after its last byte: a command
//   (stop, left, right, forward) and the white byte count of that frame.
//   Throughput is one byte per cycle within a frame. After the last byte of a
//   frame, in_stall_o stays high through the area, bytes, limit and decide
//   states while the threshold multiplies run in sequence (frame area, bytes per
//   pixel, percentage); out_valid_o rises once the result is registered. If the
//   output register is still stalled then, the input stays stalled until the old
//   result is taken, but a waiting result does not hold up the next frame's bytes.
//   Reset returns the configuration registers to their defaults, starts a new frame
//   with a centred heading and marks the robot as stopped. There is no clearing pass.
module bright_pixel_steering_decider #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bpsd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bpsd_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    data_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    command_o,
  output logic [bpsd_pkg::CountW-1:0]   white_count_o
);

  bpsd_pkg::ctrl_t   ctrl;
  bpsd_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  bpsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  bpsd_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .data_byte_i   (data_byte_i),
    .out_stall_i   (out_stall_i),
    .ctrl_i        (ctrl),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .command_o     (command_o),
    .white_count_o (white_count_o)
  );

endmodule
